FILE: rtl/core/rlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types and constants of the RGB layer blend unit.
// ----------------------------------------------------------------------------
package rlb_pkg;

    localparam int PIX_W       = 8;
    localparam int PIPE_STAGES = 4;
    localparam int PROD_W      = 2 * PIX_W + 1;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 24;

    localparam logic [PIX_W-1:0]   PIX_MAX    = 8'd255;
    localparam logic [PIX_W-1:0]   PIX_HALF   = 8'd127;
    // rounding bias of 127, plus one for the reciprocal divide
    localparam logic [PROD_W-1:0]  ROUND_BIAS = 17'd128;
    // floor(x / 255) == ((x + 1) * 65793) >> 24 for x + 1 < 2**24
    localparam logic [RECIP_W-1:0] RECIP_255  = 17'd65793;

    typedef enum logic [1:0] {
        MODE_MULTIPLY = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_OVERLAY  = 2'd3
    } blend_mode_t;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
    } stage_ctrl_t;

endpackage

FILE: rtl/core/rlb_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_pipe_ctrl
// Valid and last tracking for the blend pipeline, with per-stage load enables.
// ----------------------------------------------------------------------------
module rlb_pipe_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic                 out_last,
    input  logic                 out_ready,
    output rlb_pkg::stage_ctrl_t ctrl
);

    logic [rlb_pkg::PIPE_STAGES-1:0] valid_reg;
    logic [rlb_pkg::PIPE_STAGES-1:0] valid_next;
    logic [rlb_pkg::PIPE_STAGES-1:0] last_reg;
    logic [rlb_pkg::PIPE_STAGES:0]   ready;

    always_comb begin
        ready[rlb_pkg::PIPE_STAGES] = out_ready;
        for (int i = rlb_pkg::PIPE_STAGES - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb begin
        ctrl.en[0]    = ready[0];
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < rlb_pkg::PIPE_STAGES; i++) begin
            ctrl.en[i] = ready[i];
            if (ready[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            last_reg[0] <= in_last;
        end
        for (int i = 1; i < rlb_pkg::PIPE_STAGES; i++) begin
            if (ready[i]) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[rlb_pkg::PIPE_STAGES-1];
    assign out_last  = last_reg[rlb_pkg::PIPE_STAGES-1];

endmodule

FILE: rtl/core/rlb_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlb_channel
// Four-stage blend datapath for one color channel: operand select, product,
// reciprocal divide by 255, final select into the output register.
// ----------------------------------------------------------------------------
module rlb_channel (
    input  logic                       aclk,
    input  rlb_pkg::stage_ctrl_t       ctrl,
    input  rlb_pkg::blend_mode_t       mode,
    input  logic [rlb_pkg::PIX_W-1:0]  top,
    input  logic [rlb_pkg::PIX_W-1:0]  bottom,
    output logic [rlb_pkg::PIX_W-1:0]  result
);

    localparam int W  = rlb_pkg::PIX_W;
    localparam int PW = rlb_pkg::PROD_W;
    localparam int RW = PW + rlb_pkg::RECIP_W;

    // stage 0
    logic [W-1:0] x_next, y_next, sub_next;
    logic         dbl_next, inv_next, is_sub_next;
    logic [W-1:0] x_reg, y_reg, sub0_reg;
    logic         dbl_reg, inv0_reg, is_sub0_reg;

    // stage 1
    logic [2*W-1:0] prod;
    logic [PW-1:0]  scaled;
    logic [PW-1:0]  num_next, num_reg;
    logic [W-1:0]   sub1_reg;
    logic           inv1_reg, is_sub1_reg;

    // stage 2
    logic [RW-1:0]  recip;
    logic [W-1:0]   quot_next, quot_reg;
    logic [W-1:0]   sub2_reg;
    logic           inv2_reg, is_sub2_reg;

    // stage 3
    logic [W-1:0]   result_next, result_reg;

    always_comb begin
        x_next      = top;
        y_next      = bottom;
        dbl_next    = 1'b0;
        inv_next    = 1'b0;
        is_sub_next = 1'b0;
        sub_next    = (bottom > top) ? (bottom - top) : '0;
        unique case (mode)
            rlb_pkg::MODE_MULTIPLY: begin
            end
            rlb_pkg::MODE_SUBTRACT: begin
                is_sub_next = 1'b1;
            end
            rlb_pkg::MODE_SCREEN: begin
                x_next   = rlb_pkg::PIX_MAX - top;
                y_next   = rlb_pkg::PIX_MAX - bottom;
                inv_next = 1'b1;
            end
            rlb_pkg::MODE_OVERLAY: begin
                dbl_next = 1'b1;
                if (bottom > rlb_pkg::PIX_HALF) begin
                    x_next   = rlb_pkg::PIX_MAX - top;
                    y_next   = rlb_pkg::PIX_MAX - bottom;
                    inv_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            dbl_reg     <= dbl_next;
            inv0_reg    <= inv_next;
            is_sub0_reg <= is_sub_next;
            sub0_reg    <= sub_next;
        end
    end

    always_comb begin
        prod     = x_reg * y_reg;
        scaled   = dbl_reg ? {prod, 1'b0} : {1'b0, prod};
        num_next = scaled + rlb_pkg::ROUND_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[1]) begin
            num_reg     <= num_next;
            inv1_reg    <= inv0_reg;
            is_sub1_reg <= is_sub0_reg;
            sub1_reg    <= sub0_reg;
        end
    end

    always_comb begin
        recip     = num_reg * rlb_pkg::RECIP_255;
        quot_next = recip[rlb_pkg::RECIP_SHIFT +: W];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[2]) begin
            quot_reg    <= quot_next;
            inv2_reg    <= inv1_reg;
            is_sub2_reg <= is_sub1_reg;
            sub2_reg    <= sub1_reg;
        end
    end

    always_comb begin
        if (is_sub2_reg) begin
            result_next = sub2_reg;
        end else if (inv2_reg) begin
            result_next = rlb_pkg::PIX_MAX - quot_reg;
        end else begin
            result_next = quot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/core/rgb_layer_blend_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_layer_blend_unit_core
// Per-pixel blend of a top and a bottom RGB layer: multiply, subtract,
// screen or overlay, each channel on its own.
// ----------------------------------------------------------------------------
// Pipeline: operand select, product, reciprocal divide and final select registers
//   lie between an input transaction and m_axis_tvalid.
// Throughput: one pixel per cycle while m_axis_tready is high; each channel has one product
//   multiplier and one reciprocal multiplier, each in its own stage.
// Reset: aresetn clears the pipeline valid bits; data registers are not reset.
module rgb_layer_blend_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
    input  logic [47:0] s_axis_tdata,
    // func
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int W = rlb_pkg::PIX_W;

    rlb_pkg::stage_ctrl_t ctrl;
    rlb_pkg::blend_mode_t mode;

    assign mode = rlb_pkg::blend_mode_t'(s_axis_tuser);

    rlb_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl)
    );

    rlb_channel u_red (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .mode   (mode),
        .top    (s_axis_tdata[0*W +: W]),
        .bottom (s_axis_tdata[3*W +: W]),
        .result (m_axis_tdata[0*W +: W])
    );

    rlb_channel u_green (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .mode   (mode),
        .top    (s_axis_tdata[1*W +: W]),
        .bottom (s_axis_tdata[4*W +: W]),
        .result (m_axis_tdata[1*W +: W])
    );

    rlb_channel u_blue (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .mode   (mode),
        .top    (s_axis_tdata[2*W +: W]),
        .bottom (s_axis_tdata[5*W +: W]),
        .result (m_axis_tdata[2*W +: W])
    );

    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("pixel did not reach output within pipeline latency");

    a_stage_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> (ctrl.en == '1))
        else $error("stage held while output side is ready");

endmodule
